// ----- rtl/core/assert_macros.svh -----
// Concurrent assertion helpers clocked on clk_i and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define NGATE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define NGATE_NEVER(lbl, cond, msg) \
  `NGATE_ASSERT(lbl, !(cond), msg)

`endif

// ----- rtl/core/ngate_pkg.sv -----
// Shared constants, register codes and controller/datapath types for the noise gate.
`default_nettype none

package ngate_pkg;

  localparam int SampleBitsDef = 24;
  localparam int CoefBitsDef   = 24;
  localparam int HoldBitsDef   = 20;

  localparam int CfgIdxBits = 3;

  // Register reset values, taken at the configured widths by part-select.
  localparam logic [31:0] ThresholdRst = 32'd83886;
  localparam logic [31:0] DetAtkRst    = 32'd16427000;
  localparam logic [31:0] DetRelRst    = 32'd16773721;
  localparam logic [31:0] GainAtkRst   = 32'd16707000;
  localparam logic [31:0] GainRelRst   = 32'd16770000;
  localparam logic [31:0] HoldLenRst   = 32'd480;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_ENABLE    = 3'd0,
    CFG_THRESHOLD = 3'd1,
    CFG_DET_ATK   = 3'd2,
    CFG_DET_REL   = 3'd3,
    CFG_GAIN_ATK  = 3'd4,
    CFG_GAIN_REL  = 3'd5,
    CFG_HOLD      = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic env_mul;
    logic env_upd;
    logic gain_mul;
    logic gain_upd;
    logic out_mul;
    logic emit;
  } ngate_cmd_t;

  typedef struct packed {
    logic bypass;
    logic out_free;
  } ngate_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/ngate_if.sv -----
// Valid/ready channel interfaces for input samples and gated results.
`default_nettype none

interface ngate_in_if #(
  parameter int SampleBits = ngate_pkg::SampleBitsDef
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface ngate_out_if #(
  parameter int SampleBits = ngate_pkg::SampleBitsDef,
  parameter int CoefBits   = ngate_pkg::CoefBitsDef
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample_out;
  logic [CoefBits:0]            gain_now;
  logic                         gate_open;

  modport source (output valid, output sample_out, output gain_now, output gate_open,
                  input ready);
  modport sink (input valid, input sample_out, input gain_now, input gate_open,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ngate_dp.sv -----
// Datapath: envelope, hold counter, smoothed gain, shared multiplier and output register.
`default_nettype none

module ngate_dp #(
  parameter int SAMPLE_BITS = ngate_pkg::SampleBitsDef,
  parameter int COEF_BITS   = ngate_pkg::CoefBitsDef,
  parameter int HOLD_BITS   = ngate_pkg::HoldBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ngate_pkg::ngate_cmd_t         cmd_i,
  output      ngate_pkg::ngate_sts_t         sts_o,
  input  wire logic                          state_clr_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  wire logic                          enable_i,
  input  wire logic [SAMPLE_BITS-1:0]        threshold_i,
  input  wire logic [COEF_BITS-1:0]          det_atk_i,
  input  wire logic [COEF_BITS-1:0]          det_rel_i,
  input  wire logic [COEF_BITS-1:0]          gain_atk_i,
  input  wire logic [COEF_BITS-1:0]          gain_rel_i,
  input  wire logic [HOLD_BITS-1:0]          hold_len_i,
  ngate_out_if.source                        result_o
);
  import ngate_pkg::*;

  localparam int AW = (COEF_BITS > SAMPLE_BITS) ? COEF_BITS : SAMPLE_BITS;
  localparam int BW = (COEF_BITS + 1 > SAMPLE_BITS) ? COEF_BITS + 1 : SAMPLE_BITS;
  localparam int PW = AW + BW;
  localparam logic [COEF_BITS:0] One = {1'b1, {COEF_BITS{1'b0}}};

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS-1:0]        mag_q, mag_d;
  logic                          neg_q;
  logic [SAMPLE_BITS-1:0]        env_q, env_d;
  logic [COEF_BITS:0]            gain_q, gain_d;
  logic [HOLD_BITS-1:0]          hold_q, hold_d;
  logic                          open_q, open_d;
  logic                          up_q, up_d;
  logic [PW-1:0]                 prod_q;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q, out_sample_d;
  logic [COEF_BITS:0]            out_gain_q, out_gain_d;
  logic                          out_open_q, out_open_d;

  logic [AW-1:0]          mul_a;
  logic [BW-1:0]          mul_b;
  logic                   env_rise, gain_rise;
  logic [SAMPLE_BITS-1:0] env_diff, env_step, out_res;
  logic [COEF_BITS:0]     target, gain_diff, gain_step;
  logic [COEF_BITS-1:0]   env_coef, gain_coef;

  // Magnitude of the most negative sample is 2^(SAMPLE_BITS-1), still fits unsigned.
  assign mag_d = sample_in_i[SAMPLE_BITS-1] ? ('0 - SAMPLE_BITS'(sample_in_i))
                                            : SAMPLE_BITS'(sample_in_i);

  assign target = open_q ? One : '0;

  always_comb begin
    env_rise  = mag_q > env_q;
    env_coef  = env_rise ? det_atk_i : det_rel_i;
    env_diff  = env_rise ? (mag_q - env_q) : (env_q - mag_q);
    gain_rise = target > gain_q;
    gain_coef = gain_rise ? gain_atk_i : gain_rel_i;
    gain_diff = gain_rise ? (target - gain_q) : (gain_q - target);

    // new = in + c*(old - in); the step is truncated, so the result stays
    // between in and old and needs no clamp.
    env_step  = prod_q[COEF_BITS +: SAMPLE_BITS];
    gain_step = prod_q[COEF_BITS +: COEF_BITS + 1];
    env_d     = up_q ? (mag_q + env_step) : (mag_q - env_step);
    gain_d    = up_q ? (target + gain_step) : (target - gain_step);

    if (env_d > threshold_i) begin
      hold_d = hold_len_i;
      open_d = 1'b1;
    end else if (hold_q != '0) begin
      hold_d = hold_q - 1'b1;
      open_d = 1'b1;
    end else begin
      hold_d = hold_q;
      open_d = 1'b0;
    end

    up_d  = up_q;
    mul_a = AW'(mag_q);
    mul_b = BW'(gain_q);
    if (cmd_i.env_mul) begin
      mul_a = AW'(env_coef);
      mul_b = BW'(env_diff);
      up_d  = !env_rise;
    end else if (cmd_i.gain_mul) begin
      mul_a = AW'(gain_coef);
      mul_b = BW'(gain_diff);
      up_d  = !gain_rise;
    end

    out_res = prod_q[COEF_BITS +: SAMPLE_BITS];
    if (enable_i) begin
      out_sample_d = neg_q ? ('0 - out_res) : out_res;
      out_gain_d   = gain_q;
      out_open_d   = open_q;
    end else begin
      out_sample_d = sample_q;
      out_gain_d   = '0;
      out_open_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q       <= '0;
      gain_q      <= '0;
      hold_q      <= '0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_clr_i) begin
        env_q  <= '0;
        gain_q <= '0;
        hold_q <= '0;
        open_q <= 1'b0;
      end else begin
        if (cmd_i.env_upd) begin
          env_q  <= env_d;
          hold_q <= hold_d;
          open_q <= open_d;
        end
        if (cmd_i.gain_upd) begin
          gain_q <= gain_d;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_in_i;
      mag_q    <= mag_d;
      neg_q    <= sample_in_i[SAMPLE_BITS-1];
    end
    if (cmd_i.env_mul || cmd_i.gain_mul || cmd_i.out_mul) begin
      prod_q <= mul_a * mul_b;
      up_q   <= up_d;
    end
    if (cmd_i.emit) begin
      out_sample_q <= out_sample_d;
      out_gain_q   <= out_gain_d;
      out_open_q   <= out_open_d;
    end
  end

  assign sts_o.bypass   = !enable_i;
  assign sts_o.out_free = !out_valid_q || result_o.ready;

  assign result_o.valid      = out_valid_q;
  assign result_o.sample_out = out_sample_q;
  assign result_o.gain_now   = out_gain_q;
  assign result_o.gate_open  = out_open_q;

endmodule

`default_nettype wire

// ----- rtl/core/ngate_ctrl.sv -----
// Controller: sequences one sample at a time through the shared multiplier steps, or straight to emit in bypass.
`default_nettype none

module ngate_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire ngate_pkg::ngate_sts_t sts_i,
  output      ngate_pkg::ngate_cmd_t cmd_o
);
  import ngate_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENV_MUL,
    ST_ENV_UPD,
    ST_GAIN_MUL,
    ST_GAIN_UPD,
    ST_OUT_MUL,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = accept;
    cmd_o.env_mul  = (state_q == ST_ENV_MUL);
    cmd_o.env_upd  = (state_q == ST_ENV_UPD);
    cmd_o.gain_mul = (state_q == ST_GAIN_MUL);
    cmd_o.gain_upd = (state_q == ST_GAIN_UPD);
    cmd_o.out_mul  = (state_q == ST_OUT_MUL);
    cmd_o.emit     = (state_q == ST_EMIT) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            // pass-through words skip straight to the output register
            state_q <= sts_i.bypass ? ST_EMIT : ST_ENV_MUL;
          end
        end
        ST_ENV_MUL:  state_q <= ST_ENV_UPD;
        ST_ENV_UPD:  state_q <= ST_GAIN_MUL;
        ST_GAIN_MUL: state_q <= ST_GAIN_UPD;
        ST_GAIN_UPD: state_q <= ST_OUT_MUL;
        ST_OUT_MUL:  state_q <= ST_EMIT;
        ST_EMIT: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/audio_noise_gate_with_hold.sv -----
// Noise gate top level: register file, controller, datapath and checks.
//
// Usage: samples enter on sample_i (valid/ready, one signed word each) and
// one result word leaves on result_o per sample: the gated sample, the
// smoothed gain after that sample (Q1.COEF_BITS) and the gate-open flag.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i, one per
// cycle, while no sample is in flight; index 0 enable, 1 threshold,
// 2/3 detector attack/release, 4/5 gain attack/release, 6 hold length.
// Writing enable = 0 clears envelope, gain and hold count at once.
// An accepted sample passes through envelope multiply, envelope update,
// gain multiply, gain update and output multiply, then is loaded into the
// output register, which drives result_o; only then is a new sample taken.
// The single multiplier is used three times per sample (envelope step,
// gain step, output product), the first two each followed by an update.
// With enable = 0 an accepted sample goes straight to the output register.
// Reset: registers return to their defaults, gate state is zero, the
// output register is empty. If the receiver stalls, the finished word
// waits in the output register while the next sample is still accepted
// and worked on; that one waits in its last step until the word is taken.
`default_nettype none

`include "assert_macros.svh"

module audio_noise_gate_with_hold #(
  parameter int SAMPLE_BITS = ngate_pkg::SampleBitsDef,
  parameter int COEF_BITS   = ngate_pkg::CoefBitsDef,
  parameter int HOLD_BITS   = ngate_pkg::HoldBitsDef,
  parameter int CFG_BITS    = (SAMPLE_BITS > COEF_BITS)
                              ? ((SAMPLE_BITS > HOLD_BITS) ? SAMPLE_BITS : HOLD_BITS)
                              : ((COEF_BITS > HOLD_BITS) ? COEF_BITS : HOLD_BITS)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [ngate_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [CFG_BITS-1:0]              cfg_data_i,
  ngate_in_if.sink                              sample_i,
  ngate_out_if.source                           result_o
);
  import ngate_pkg::*;

  localparam logic [COEF_BITS:0] One = {1'b1, {COEF_BITS{1'b0}}};

  logic                   enable_q;
  logic [SAMPLE_BITS-1:0] threshold_q;
  logic [COEF_BITS-1:0]   det_atk_q, det_rel_q, gain_atk_q, gain_rel_q;
  logic [HOLD_BITS-1:0]   hold_len_q;
  logic                   state_clr;

  ngate_cmd_t cmd;
  ngate_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      threshold_q <= ThresholdRst[SAMPLE_BITS-1:0];
      det_atk_q   <= DetAtkRst[COEF_BITS-1:0];
      det_rel_q   <= DetRelRst[COEF_BITS-1:0];
      gain_atk_q  <= GainAtkRst[COEF_BITS-1:0];
      gain_rel_q  <= GainRelRst[COEF_BITS-1:0];
      hold_len_q  <= HoldLenRst[HOLD_BITS-1:0];
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE:    enable_q    <= cfg_data_i[0];
        CFG_THRESHOLD: threshold_q <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_DET_ATK:   det_atk_q   <= cfg_data_i[COEF_BITS-1:0];
        CFG_DET_REL:   det_rel_q   <= cfg_data_i[COEF_BITS-1:0];
        CFG_GAIN_ATK:  gain_atk_q  <= cfg_data_i[COEF_BITS-1:0];
        CFG_GAIN_REL:  gain_rel_q  <= cfg_data_i[COEF_BITS-1:0];
        CFG_HOLD:      hold_len_q  <= cfg_data_i[HOLD_BITS-1:0];
        default:       ;
      endcase
    end
  end

  assign state_clr = cfg_we_i && (cfg_idx_i == CFG_ENABLE) && !cfg_data_i[0];

  ngate_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ngate_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .HOLD_BITS   (HOLD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .state_clr_i (state_clr),
    .sample_in_i (sample_i.sample_in),
    .enable_i    (enable_q),
    .threshold_i (threshold_q),
    .det_atk_i   (det_atk_q),
    .det_rel_i   (det_rel_q),
    .gain_atk_i  (gain_atk_q),
    .gain_rel_i  (gain_rel_q),
    .hold_len_i  (hold_len_q),
    .result_o    (result_o)
  );

  // one sample in flight at a time
  `NGATE_ASSERT(a_one_in_flight, (sample_i.valid && sample_i.ready) |=> !sample_i.ready, "busy")
  // smoothing never carries the gain past unity
  `NGATE_NEVER(a_gain_range, result_o.valid && (result_o.gain_now > One), "gain above unity")
  // an open gate has always moved the gain off zero
  `NGATE_ASSERT(a_open_gain, (result_o.valid && result_o.gate_open) |-> |result_o.gain_now, "no gain")

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Noise gate testbench: directed table, then random loud/quiet bursts checked against a predictor.
module tb;
  import ngate_pkg::*;

  localparam int SW = SampleBitsDef;
  localparam int CW = CoefBitsDef;
  localparam int HW = HoldBitsDef;
  localparam int DW = (SW > CW) ? ((SW > HW) ? SW : HW) : ((CW > HW) ? CW : HW);
  localparam logic [CW:0] UNITY = {1'b1, {CW{1'b0}}};
  localparam logic [CfgIdxBits-1:0] CFG_NONE = 3'd7;  // no register here, write is dropped
  localparam int DRAIN = 10;
  localparam int HOLDOFF = 150;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 62;
  localparam int END_WAIT = 50000;

  typedef struct packed {
    logic signed [SW-1:0] smp;
    logic [CW:0]          gain;
    logic                 open;
  } gate_word_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CfgIdxBits-1:0] idx;
    logic [DW-1:0]         val;
    logic                  typed;
    gate_word_t            want;
  } plan_row_t;

  localparam gate_word_t SHUT = '0;

  localparam plan_row_t PLAN [32] = '{
    '{ROW_SAMPLE, CFG_ENABLE, 24'd0, 1'b1, SHUT},
    '{ROW_SAMPLE, CFG_ENABLE, 24'd8388607, 1'b0, SHUT},
    '{ROW_SAMPLE, CFG_ENABLE, 24'h800000, 1'b0, SHUT},
    // zero coefficients: envelope and gain jump straight to their targets
    '{ROW_WRITE, CFG_DET_ATK, 24'd0, 1'b0, SHUT},
    '{ROW_WRITE, CFG_DET_REL, 24'd0, 1'b0, SHUT},
    '{ROW_WRITE, CFG_GAIN_ATK, 24'd0, 1'b0, SHUT},
    '{ROW_WRITE, CFG_GAIN_REL, 24'd0, 1'b0, SHUT},
    '{ROW_WRITE, CFG_THRESHOLD, 24'd1000, 1'b0, SHUT},
    '{ROW_WRITE, CFG_HOLD, 24'hF00002, 1'b0, SHUT},   // upper bits masked off: hold 2
    '{ROW_WRITE, CFG_NONE, 24'hFFFFFF, 1'b0, SHUT},
    '{ROW_SAMPLE, CFG_ENABLE, 24'h800000, 1'b1, '{24'h800000, UNITY, 1'b1}},
    '{ROW_SAMPLE, CFG_ENABLE, 24'd8388607, 1'b1, '{24'd8388607, UNITY, 1'b1}},
    // envelope at threshold does not count as above it: hold keeps the gate open two words
    '{ROW_SAMPLE, CFG_ENABLE, 24'd1000, 1'b1, '{24'd1000, UNITY, 1'b1}},
    '{ROW_SAMPLE, CFG_ENABLE, -24'sd1000, 1'b1, '{-24'sd1000, UNITY, 1'b1}},
    '{ROW_SAMPLE, CFG_ENABLE, 24'd1000, 1'b1, SHUT},
    '{ROW_SAMPLE, CFG_ENABLE, 24'd1001, 1'b1, '{24'd1001, UNITY, 1'b1}},
    '{ROW_SAMPLE, CFG_ENABLE, -24'sd1, 1'b1, '{-24'sd1, UNITY, 1'b1}},
    '{ROW_WRITE, CFG_DET_ATK, 24'hFFFFFF, 1'b0, SHUT},
    '{ROW_WRITE, CFG_DET_REL, 24'hFFFFFF, 1'b0, SHUT},
    '{ROW_WRITE, CFG_GAIN_ATK, 24'hFFFFFF, 1'b0, SHUT},
    '{ROW_WRITE, CFG_GAIN_REL, 24'hFFFFFF, 1'b0, SHUT},
    '{ROW_SAMPLE, CFG_ENABLE, 24'd8388607, 1'b0, SHUT},
    '{ROW_SAMPLE, CFG_ENABLE, 24'h800000, 1'b0, SHUT},
    '{ROW_SAMPLE, CFG_ENABLE, 24'd0, 1'b0, SHUT},
    '{ROW_SAMPLE, CFG_ENABLE, 24'd5, 1'b0, SHUT},
    // only bit 0 counts: this disables
    '{ROW_WRITE, CFG_ENABLE, 24'hFFFFFE, 1'b0, SHUT},
    '{ROW_SAMPLE, CFG_ENABLE, 24'd8388607, 1'b1, '{24'd8388607, 25'd0, 1'b0}},
    '{ROW_SAMPLE, CFG_ENABLE, 24'h800000, 1'b1, '{24'h800000, 25'd0, 1'b0}},
    '{ROW_SAMPLE, CFG_ENABLE, 24'd0, 1'b1, SHUT},
    '{ROW_SAMPLE, CFG_ENABLE, -24'sd1, 1'b1, '{-24'sd1, 25'd0, 1'b0}},
    '{ROW_WRITE, CFG_ENABLE, 24'd1, 1'b0, SHUT},
    '{ROW_SAMPLE, CFG_ENABLE, 24'd0, 1'b1, SHUT}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CfgIdxBits-1:0] cfg_idx;
  logic [DW-1:0]         cfg_data;

  ngate_in_if  #(.SampleBits(SW))                in_ch ();
  ngate_out_if #(.SampleBits(SW), .CoefBits(CW)) out_ch ();

  audio_noise_gate_with_hold u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .sample_i   (in_ch),
    .result_o   (out_ch)
  );

  // register copies
  logic          gate_en;
  logic [SW-1:0] thr_lvl;
  logic [CW-1:0] det_atk, det_rel, g_atk, g_rel;
  logic [HW-1:0] hold_len;
  // gate state
  logic [SW-1:0] env_lvl;
  logic [CW:0]   gain_lvl;
  logic [HW-1:0] hold_cnt;

  gate_word_t pending_words[$];
  gate_word_t head;
  int mismatches = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // new = in + c*(old - in), product truncated toward zero
  function automatic longint unsigned pole_step(input longint unsigned tgt,
                                                input longint unsigned prev,
                                                input longint unsigned c);
    if (prev >= tgt) return tgt + ((c * (prev - tgt)) >> CW);
    return tgt - ((c * (tgt - prev)) >> CW);
  endfunction

  function automatic gate_word_t gate_predict(input logic [SW-1:0] raw);
    gate_word_t      w;
    longint unsigned mag, prod, nxt, tgt;
    logic            open;
    mag = raw[SW-1] ? (64'd1 << SW) - 64'(raw) : 64'(raw);
    if (!gate_en) begin
      env_lvl = '0;
      gain_lvl = '0;
      hold_cnt = '0;
      w.smp = raw;
      w.gain = '0;
      w.open = 1'b0;
      return w;
    end
    if (mag > env_lvl) env_lvl = SW'(pole_step(mag, env_lvl, det_atk));
    else env_lvl = SW'(pole_step(mag, env_lvl, det_rel));
    if (env_lvl > thr_lvl) begin
      open = 1'b1;
      hold_cnt = hold_len;
    end else if (hold_cnt != 0) begin
      hold_cnt = hold_cnt - 1'b1;
      open = 1'b1;
    end else begin
      open = 1'b0;
    end
    tgt = open ? 64'(UNITY) : 64'd0;
    if (tgt > gain_lvl) begin
      nxt = pole_step(tgt, gain_lvl, g_atk);
      gain_lvl = (CW+1)'((nxt > tgt) ? tgt : nxt);
    end else if (tgt < gain_lvl) begin
      nxt = pole_step(tgt, gain_lvl, g_rel);
      gain_lvl = (CW+1)'((nxt < tgt) ? tgt : nxt);
    end
    prod = (mag * gain_lvl) >> CW;
    if (raw[SW-1]) prod = -prod;
    w.smp = prod[SW-1:0];
    w.gain = gain_lvl;
    w.open = open;
    return w;
  endfunction

  function automatic logic [DW-1:0] pick_coef(input int p);
    if (p < 2) return p ? '1 : '0;
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return DW'($urandom());
      default: return DW'(24'hFFFFFF - $urandom_range(1 << 18));  // slow, like real settings
    endcase
  endfunction

  function automatic logic [SW-1:0] make_sample(input int kind);
    logic [SW-1:0] m;
    case (kind)
      0, 1, 2, 3: m = SW'($urandom_range(8388607, 1 << 20));
      4, 5, 6: m = SW'($urandom_range(255));
      7: return '0;
      8: return SW'($urandom());
      default: begin
        case ($urandom_range(3))
          0: return 24'h800000;
          1: return 24'h7FFFFF;
          2: return '1;
          default: return 24'd1;
        endcase
      end
    endcase
    return $urandom_range(1) ? -m : m;
  endfunction

  task automatic send_sample(input logic [SW-1:0] s, input logic typed, input gate_word_t want);
    gate_word_t w;
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_in <= s;
    do @(posedge clk_i); while (!in_ch.ready);
    w = gate_predict(s);
    pending_words.push_back(typed ? want : w);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [DW-1:0] d);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= d;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENABLE: begin
        gate_en = d[0];
        if (!d[0]) begin
          env_lvl = '0;
          gain_lvl = '0;
          hold_cnt = '0;
        end
      end
      CFG_THRESHOLD: thr_lvl = d[SW-1:0];
      CFG_DET_ATK:   det_atk = d[CW-1:0];
      CFG_DET_REL:   det_rel = d[CW-1:0];
      CFG_GAIN_ATK:  g_atk = d[CW-1:0];
      CFG_GAIN_REL:  g_rel = d[CW-1:0];
      CFG_HOLD:      hold_len = d[HW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLDOFF;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected: sample_out %0d", out_ch.sample_out);
        mismatches++;
      end else begin
        head = pending_words.pop_front();
        if (out_ch.sample_out !== head.smp) begin
          $error("sample_out: expected %0d, got %0d", head.smp, out_ch.sample_out);
          mismatches++;
        end
        if (out_ch.gain_now !== head.gain) begin
          $error("gain_now: expected %0d, got %0d", head.gain, out_ch.gain_now);
          mismatches++;
        end
        if (out_ch.gate_open !== head.open) begin
          $error("gate_open: expected %0d, got %0d", head.open, out_ch.gate_open);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [DW-1:0] d;
    int sent, seg, kind, sel, waited;
    bit paused;
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_ENABLE;
    cfg_data = '0;
    rst_ni = 1'b0;
    gate_en = 1'b1;
    thr_lvl = ThresholdRst[SW-1:0];
    det_atk = DetAtkRst[CW-1:0];
    det_rel = DetRelRst[CW-1:0];
    g_atk = GainAtkRst[CW-1:0];
    g_rel = GainRelRst[CW-1:0];
    hold_len = HoldLenRst[HW-1:0];
    env_lvl = '0;
    gain_lvl = '0;
    hold_cnt = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(PLAN); i++) begin
      if (PLAN[i].kind == ROW_WRITE) write_reg(PLAN[i].idx, PLAN[i].val);
      else send_sample(PLAN[i].val[SW-1:0], PLAN[i].typed, PLAN[i].want);
    end

    // first two phases pin every register but enable (kept on) to its low and high extreme
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 63; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 63; end
        default: begin send_gap_pct = 24; stall_pct = 24; end
      endcase
      d = DW'($urandom());
      d[0] = (p < 2) || ($urandom_range(5) != 0);
      write_reg(CFG_ENABLE, d);
      sel = (p < 2) ? p : $urandom_range(5);
      case (sel)
        0: d = '0;
        1: d = '1;
        2: d = 24'h800000;
        3: d = 24'h7FFFFF;
        4: d = DW'($urandom_range(1 << 20));
        default: d = DW'($urandom());
      endcase
      write_reg(CFG_THRESHOLD, d);
      write_reg(CFG_DET_ATK, pick_coef(p));
      write_reg(CFG_DET_REL, pick_coef(p));
      write_reg(CFG_GAIN_ATK, pick_coef(p));
      write_reg(CFG_GAIN_REL, pick_coef(p));
      d = DW'($urandom());
      sel = (p < 2) ? p : $urandom_range(4);
      case (sel)
        0: d[HW-1:0] = '0;
        1: d[HW-1:0] = '1;
        2: d[HW-1:0] = HW'($urandom_range(8, 1));
        3: d[HW-1:0] = HW'($urandom_range(60));
        default: d[HW-1:0] = HW'($urandom());
      endcase
      write_reg(CFG_HOLD, d);

      if (p == 4) hold_req++;  // long output stall while words keep coming
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        if (p == 5 && !paused && sent >= PHASE_ITEMS / 2) begin
          paused = 1'b1;
          wait_idle();
        end
        seg = $urandom_range(24, 1);
        kind = $urandom_range(9);
        for (int k = 0; k < seg && sent < PHASE_ITEMS; k++) begin
          send_sample(make_sample(kind), 1'b0, SHUT);
          sent++;
        end
      end
    end

    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_words.size() != 0 && waited < END_WAIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      $error("%0d result words never arrived", pending_words.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
